>>> hdl/fpsq_pkg.sv
package fpsq_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_BYTES = 64;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(SLOT_BYTES);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int HELD_W = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);
    localparam int ERR_W  = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0] HDR_SYNC = 8'h06;
    localparam logic [7:0] HDR_KIND = 8'h85;

    typedef enum logic [2:0] {
        SEL_SYNC,
        SEL_KIND,
        SEL_DEST,
        SEL_SRC,
        SEL_LEN,
        SEL_PAY
    } byte_sel_t;

    typedef struct packed {
        logic               accept;
        logic               drop;
        logic               clear_fill;
        logic               put;
        byte_sel_t          sel;
        logic               commit;
        logic               issue;
        logic               issue_const;
        logic               const_sent;
        logic               rd_last;
        logic [POS_W-1:0]   rd_pos;
        logic               finish;
    } fpsq_cmd_t;

    typedef struct packed {
        logic               in_op;
        logic               in_first;
        logic               fin;
        logic               busy;
        logic               held_zero;
        logic               held_full;
        logic [LEN_W-1:0]   oldest_len;
        logic               can_issue;
    } fpsq_stat_t;

endpackage

>>> hdl/fpsq_ctrl.sv
module fpsq_ctrl
    import fpsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  fpsq_stat_t stat,
    output fpsq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAY,
        ST_SEND
    } state_t;

    state_t           state_reg, state_next;
    byte_sel_t        hdr_reg, hdr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             last_pos;

    assign s_tready = (state_reg == ST_IDLE);
    assign last_pos = ((LEN_W'(pos_reg) + LEN_W'(1)) == stat.oldest_len);

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_PAY;
        state_next = state_reg;
        hdr_next   = hdr_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.in_op)
                    begin
                        // queue full: the fill slot is the oldest, drop it
                        cmd.drop = stat.held_full;
                        if (stat.in_first)
                        begin
                            cmd.clear_fill = 1'b1;
                            hdr_next       = SEL_SYNC;
                            state_next     = ST_HDR;
                        end
                        else
                        begin
                            state_next = ST_PAY;
                        end
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_SEND;
                    end
                end
            end
            ST_HDR:
            begin
                cmd.put = 1'b1;
                cmd.sel = hdr_reg;
                case (hdr_reg)
                    SEL_SYNC: hdr_next = SEL_KIND;
                    SEL_KIND: hdr_next = SEL_DEST;
                    SEL_DEST: hdr_next = SEL_SRC;
                    SEL_SRC:  hdr_next = SEL_LEN;
                    default:  state_next = ST_PAY;
                endcase
            end
            ST_PAY:
            begin
                cmd.put    = 1'b1;
                cmd.sel    = SEL_PAY;
                cmd.commit = stat.fin;
                state_next = ST_IDLE;
            end
            ST_SEND:
            begin
                if (stat.can_issue)
                begin
                    cmd.issue = 1'b1;
                    if (stat.held_zero || stat.busy)
                    begin
                        cmd.issue_const = 1'b1;
                        cmd.rd_last     = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else if (stat.oldest_len == '0)
                    begin
                        cmd.issue_const = 1'b1;
                        cmd.const_sent  = 1'b1;
                        cmd.rd_last     = 1'b1;
                        cmd.finish      = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_pos  = pos_reg;
                        cmd.rd_last = last_pos;
                        if (last_pos)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hdr_reg   <= SEL_SYNC;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hdr_reg   <= hdr_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

>>> hdl/fpsq_dp.sv
module fpsq_dp
    import fpsq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // dest, source, length_code, payload, dma_busy
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // op, first
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte, full_errors
    output logic                   m_tuser,   // sent
    output logic                   m_tlast,
    input  fpsq_cmd_t              cmd,
    output fpsq_stat_t             stat
);

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [POS_W-1:0]  p);
        mem_addr = ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(p);
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    logic [7:0] mem [SLOTS*SLOT_BYTES];

    // latched item
    logic [7:0] dest_reg, src_reg, lcode_reg, pay_reg;
    logic       fin_reg, busy_reg;

    // queue state
    logic [SLOT_W-1:0] fill_reg, oldest_reg;
    logic [HELD_W-1:0] held_reg;
    logic [ERR_W-1:0]  drop_reg;
    logic [POS_W-1:0]  fill_pos_reg;
    logic [LEN_W-1:0]  fill_len_reg;
    logic [LEN_W-1:0]  slot_len_reg [SLOTS];

    // read stage and output stage
    logic             rd_valid_reg, rd_zero_reg, rd_last_reg, rd_sent_reg;
    logic [7:0]       rd_mem_reg;
    logic [ERR_W-1:0] rd_err_reg;
    logic             out_valid_reg, out_last_reg, out_sent_reg;
    logic [7:0]       out_byte_reg;
    logic [ERR_W-1:0] out_err_reg;

    logic             load_now;
    logic [7:0]       wr_byte;
    logic [POS_W-1:0] put_pos;
    logic [LEN_W-1:0] put_len;

    assign load_now = rd_valid_reg && (!out_valid_reg || m_tready);

    assign stat.in_op      = s_tuser[0];
    assign stat.in_first   = s_tuser[1];
    assign stat.fin        = fin_reg;
    assign stat.busy       = busy_reg;
    assign stat.held_zero  = (held_reg == '0);
    assign stat.held_full  = (held_reg == HELD_W'(SLOTS));
    assign stat.oldest_len = slot_len_reg[oldest_reg];
    assign stat.can_issue  = !rd_valid_reg || load_now;

    assign put_pos = (fill_pos_reg == POS_W'(SLOT_BYTES - 1)) ? '0 : fill_pos_reg + POS_W'(1);
    assign put_len = (fill_len_reg == LEN_W'(SLOT_BYTES)) ? fill_len_reg
                                                           : fill_len_reg + LEN_W'(1);

    always_comb
    begin
        case (cmd.sel)
            SEL_SYNC: wr_byte = HDR_SYNC;
            SEL_KIND: wr_byte = HDR_KIND;
            SEL_DEST: wr_byte = dest_reg;
            SEL_SRC:  wr_byte = src_reg;
            SEL_LEN:  wr_byte = lcode_reg;
            default:  wr_byte = pay_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            mem[mem_addr(fill_reg, fill_pos_reg)] <= wr_byte;
        end
        if (cmd.issue && !cmd.issue_const)
        begin
            rd_mem_reg <= mem[mem_addr(oldest_reg, cmd.rd_pos)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dest_reg  <= s_tdata[7:0];
            src_reg   <= s_tdata[15:8];
            lcode_reg <= s_tdata[23:16];
            pay_reg   <= s_tdata[31:24];
            busy_reg  <= s_tdata[32];
            fin_reg   <= s_tlast;
        end
        if (cmd.issue)
        begin
            rd_zero_reg <= cmd.issue_const;
            rd_last_reg <= cmd.rd_last;
            rd_sent_reg <= !cmd.issue_const || cmd.const_sent;
            rd_err_reg  <= drop_reg;
        end
        if (load_now)
        begin
            out_byte_reg <= rd_zero_reg ? 8'h00 : rd_mem_reg;
            out_last_reg <= rd_last_reg;
            out_sent_reg <= rd_sent_reg;
            out_err_reg  <= rd_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            oldest_reg    <= '0;
            held_reg      <= '0;
            drop_reg      <= '0;
            fill_pos_reg  <= '0;
            fill_len_reg  <= '0;
            slot_len_reg  <= '{default: '0};
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.drop)
            begin
                oldest_reg <= next_slot(oldest_reg);
                held_reg   <= held_reg - HELD_W'(1);
                if (drop_reg != '1)
                begin
                    drop_reg <= drop_reg + ERR_W'(1);
                end
            end
            if (cmd.drop || cmd.clear_fill)
            begin
                fill_pos_reg <= '0;
                fill_len_reg <= '0;
            end
            if (cmd.put)
            begin
                fill_pos_reg <= put_pos;
                fill_len_reg <= put_len;
            end
            // commit: slot length goes to the table, fresh fill slot starts empty
            if (cmd.commit)
            begin
                slot_len_reg[fill_reg] <= put_len;
                fill_pos_reg           <= '0;
                fill_len_reg           <= '0;
                fill_reg               <= next_slot(fill_reg);
                held_reg               <= held_reg + HELD_W'(1);
            end
            if (cmd.finish)
            begin
                oldest_reg <= next_slot(oldest_reg);
                held_reg   <= held_reg - HELD_W'(1);
            end

            if (cmd.issue)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (load_now)
            begin
                rd_valid_reg <= 1'b0;
            end

            if (load_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_err_reg, out_byte_reg};
    assign m_tuser  = out_sent_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/framed_packet_send_queue.sv
// Payload word: a plain byte is written to the fill slot; a first byte is preceded by five
// header writes through the single store write port. No word is taken until they are done.
// Send request: each word passes a read stage and an output stage, one word per cycle from
// the slot store read port unless m_tready stalls it; a refusal gives a single zero word.
// Reset clears pointers, counts, slot lengths and both output stages; the byte store
// itself is not cleared.
module framed_packet_send_queue
    import fpsq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // dest, source, length_code, payload, dma_busy
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // op, first
    input  logic                   s_tlast,   // final_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte, full_errors
    output logic                   m_tuser,   // sent
    output logic                   m_tlast    // last
);

    fpsq_cmd_t  cmd;
    fpsq_stat_t stat;

    fpsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpsq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
